>>> hdl/vpsa_pkg.sv
// Package: shared types, constants and helpers of the voxel statistics accumulator.
package vpsa_pkg;

   localparam int unsigned VOXEL_COUNT_DEF = 65536;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned GRID_W = 11;
   localparam int unsigned COORD_W = 32;
   localparam int unsigned SUM_W = 64;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned PROD_N = 6;
   localparam int unsigned FQ_DEPTH = 4;
   localparam int unsigned FQ_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_INV_RES  = 3'd3,
      CSR_GRID_W   = 3'd4,
      CSR_GRID_H   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic [15:0]        voxel_index;
      logic               out_of_grid;
      logic [31:0]        point_count;
      logic signed [63:0] sum_x;
      logic signed [63:0] sum_y;
      logic signed [63:0] sum_z;
      logic signed [63:0] sum_xx;
      logic signed [63:0] sum_xy;
      logic signed [63:0] sum_xz;
      logic signed [63:0] sum_yy;
      logic signed [63:0] sum_yz;
      logic signed [63:0] sum_zz;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [31:0]        inv_res;
      logic [10:0]        grid_w;
      logic [10:0]        grid_h;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_CLEAR, BK_IDLE, BK_READ, BK_MUL, BK_ADD, BK_WRITE, BK_OUT
   } bk_state_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

endpackage

>>> hdl/vpsa_front.sv
// Front end: maps a point to its voxel index and classifies it as in or out of grid.
module vpsa_front #(
   parameter int unsigned VOXEL_COUNT = vpsa_pkg::VOXEL_COUNT_DEF,
   parameter int unsigned IDX_W = $clog2(VOXEL_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  vpsa_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  vpsa_pkg::req_type req_data,
   output logic              fr_valid,
   input  logic              fr_stall,
   output vpsa_pkg::req_type fr_point,
   output logic [IDX_W-1:0]  fr_index,
   output logic [15:0]       fr_index16,
   output logic              fr_drop
);
   // stage 1: offsets, stage 2: products, stage 3: coordinates, stage 4: linear index
   logic                     s1_v_ff, s1_v_in;
   logic                     s2_v_ff, s3_v_ff, s4_v_ff;
   vpsa_pkg::req_type        p1_ff, p2_ff, p3_ff, p4_ff;
   logic [32:0]              mag_ff [3];
   logic                     neg_ff [3];
   logic [64:0]              prod_ff [3];
   logic                     neg2_ff [3];
   logic [31:0]              crd_ff [3];
   logic [63:0]              inner_ff;
   logic                     bad3_ff;
   logic [63:0]              lin_ff;
   logic                     bad4_ff;
   logic                     adv;
   logic signed [32:0]       d [3];
   logic signed [31:0]       org [3];
   logic [31:0]              pt [3];
   logic [63:0]              q [3];
   logic                     bad3;
   logic [63:0]              inner;

   assign adv = !(s4_v_ff && fr_stall);
   assign req_stall = !adv;
   assign s1_v_in = req_valid && adv;

   always_comb begin
      org[0] = cfg.origin_x; org[1] = cfg.origin_y; org[2] = cfg.origin_z;
      pt[0] = req_data.point_x; pt[1] = req_data.point_y; pt[2] = req_data.point_z;
      bad3 = 1'b0;
      for (int a = 0; a < 3; a++) begin
         d[a] = {pt[a][31], pt[a]} - {org[a][31], org[a]};
         q[a] = prod_ff[a][63:0] >> 32;
         if (neg2_ff[a] && q[a] != 64'd0) bad3 = 1'b1;
      end
      inner = {32'd0, q[1][31:0]} + 64'(cfg.grid_h) * {32'd0, q[2][31:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0; s3_v_ff <= 1'b0; s4_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= s1_v_in; s2_v_ff <= s1_v_ff; s3_v_ff <= s2_v_ff; s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= req_data; p2_ff <= p1_ff; p3_ff <= p2_ff; p4_ff <= p3_ff;
         for (int a = 0; a < 3; a++) begin
            neg_ff[a]  <= d[a][32];
            mag_ff[a]  <= d[a][32] ? 33'(-d[a]) : 33'(d[a]);
            prod_ff[a] <= 65'(mag_ff[a] * cfg.inv_res);
            neg2_ff[a] <= neg_ff[a];
            crd_ff[a]  <= q[a][31:0];
         end
         bad3_ff  <= bad3;
         inner_ff <= inner;
         bad4_ff  <= bad3_ff || (crd_ff[0] >= 32'(cfg.grid_w))
                     || (crd_ff[1] >= 32'(cfg.grid_h));
         lin_ff   <= 64'(crd_ff[0]) + 64'(cfg.grid_w) * inner_ff;
      end
   end

   assign fr_valid   = s4_v_ff;
   assign fr_point   = p4_ff;
   assign fr_index   = lin_ff[IDX_W-1:0];
   assign fr_index16 = lin_ff[15:0];
   assign fr_drop    = bad4_ff || (lin_ff >= 64'(VOXEL_COUNT));
endmodule

>>> hdl/vpsa_queue.sv
// Short queue carrying classified points from the front end to the back end.
module vpsa_queue #(
   parameter int unsigned W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_pop,
   output logic [W-1:0] out_data
);
   logic [W-1:0]                    mem_ff [vpsa_pkg::FQ_DEPTH];
   logic [vpsa_pkg::FQ_IDX_W-1:0]   wp_ff, rp_ff;
   logic [vpsa_pkg::FQ_IDX_W:0]     cnt_ff;
   logic                            push, pop;

   assign in_stall  = (cnt_ff == (vpsa_pkg::FQ_IDX_W+1)'(vpsa_pkg::FQ_DEPTH));
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != '0);
   assign pop       = out_pop && out_valid;
   assign out_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

>>> hdl/vpsa_back.sv
// Back end: clearing pass, read-modify-write of the voxel store and result register.
module vpsa_back #(
   parameter int unsigned VOXEL_COUNT = vpsa_pkg::VOXEL_COUNT_DEF,
   parameter int unsigned IDX_W = $clog2(VOXEL_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  vpsa_pkg::req_type q_point,
   input  logic [IDX_W-1:0]  q_index,
   input  logic [15:0]       q_index16,
   input  logic              q_drop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vpsa_pkg::rsp_type rsp_data,
   output logic              busy_clear
);
   localparam int unsigned ROW_W = vpsa_pkg::CNT_W + 9 * vpsa_pkg::SUM_W;

   logic [ROW_W-1:0]             store [VOXEL_COUNT];
   vpsa_pkg::bk_state_type       st_ff, st_in;
   logic [IDX_W:0]               clr_ff, clr_in;
   logic [ROW_W-1:0]             rd_ff;
   logic signed [63:0]           prod_ff [vpsa_pkg::PROD_N];
   vpsa_pkg::rsp_type            res_ff, res_in;
   logic                         rv_ff, rv_in;
   logic                         we;
   logic [IDX_W-1:0]             wa;
   logic [ROW_W-1:0]             wd;
   logic                         mul_en;
   logic signed [31:0]           px, py, pz;
   logic [31:0]                  cnt;

   assign px = q_point.point_x;
   assign py = q_point.point_y;
   assign pz = q_point.point_z;
   assign cnt = rd_ff[ROW_W-1 -: 32];

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; rv_in = rv_ff; res_in = res_ff;
      we = 1'b0; wa = q_index; wd = res_ff[ROW_W-1:0];
      q_pop = 1'b0; mul_en = 1'b0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (st_ff)
         vpsa_pkg::BK_CLEAR: begin
            we = 1'b1; wa = clr_ff[IDX_W-1:0]; wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (IDX_W+1)'(VOXEL_COUNT - 1)) st_in = vpsa_pkg::BK_IDLE;
         end
         vpsa_pkg::BK_IDLE: begin
            if (q_valid && !rv_ff) begin
               if (q_drop) begin
                  res_in = '0; res_in.out_of_grid = 1'b1;
                  rv_in = 1'b1; q_pop = 1'b1;
               end else begin
                  st_in = vpsa_pkg::BK_READ;
               end
            end
         end
         vpsa_pkg::BK_READ: st_in = vpsa_pkg::BK_MUL;
         vpsa_pkg::BK_MUL: begin mul_en = 1'b1; st_in = vpsa_pkg::BK_ADD; end
         vpsa_pkg::BK_ADD: begin
            res_in.voxel_index = q_index16;
            res_in.out_of_grid = 1'b0;
            res_in.point_count = (cnt == '1) ? cnt : cnt + 1'b1;
            res_in.sum_x  = vpsa_pkg::sat_add(rd_ff[575:512], 64'(px));
            res_in.sum_y  = vpsa_pkg::sat_add(rd_ff[511:448], 64'(py));
            res_in.sum_z  = vpsa_pkg::sat_add(rd_ff[447:384], 64'(pz));
            res_in.sum_xx = vpsa_pkg::sat_add(rd_ff[383:320], prod_ff[0]);
            res_in.sum_xy = vpsa_pkg::sat_add(rd_ff[319:256], prod_ff[1]);
            res_in.sum_xz = vpsa_pkg::sat_add(rd_ff[255:192], prod_ff[2]);
            res_in.sum_yy = vpsa_pkg::sat_add(rd_ff[191:128], prod_ff[3]);
            res_in.sum_yz = vpsa_pkg::sat_add(rd_ff[127:64],  prod_ff[4]);
            res_in.sum_zz = vpsa_pkg::sat_add(rd_ff[63:0],    prod_ff[5]);
            st_in = vpsa_pkg::BK_WRITE;
         end
         vpsa_pkg::BK_WRITE: begin
            we = 1'b1;
            st_in = vpsa_pkg::BK_OUT;
         end
         vpsa_pkg::BK_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1; q_pop = 1'b1; st_in = vpsa_pkg::BK_IDLE;
            end
         end
         default: st_in = vpsa_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= vpsa_pkg::BK_CLEAR; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (mul_en) begin
         prod_ff[0] <= px * px; prod_ff[1] <= px * py; prod_ff[2] <= px * pz;
         prod_ff[3] <= py * py; prod_ff[4] <= py * pz; prod_ff[5] <= pz * pz;
      end
   end

   always_ff @(posedge clock) begin
      if (we) store[wa] <= wd;
      rd_ff <= store[q_index];
   end

   assign rsp_valid  = rv_ff;
   assign rsp_data   = res_ff;
   assign busy_clear = (st_ff == vpsa_pkg::BK_CLEAR);
endmodule

>>> hdl/voxel_point_statistics_accumulator_core.sv
// Top level: voxel point statistics accumulator with CSRs, front end, queue and back end.
// Path: an accepted point passes the four front stages and the queue, then the back end
// raises rsp_valid from its result register, for in-grid and dropped points alike.
// The back end takes a new point only when done with the last one, paced by the store
// read-modify-write sequence and the wait for the result register to be taken.
// Reset: synchronous; CSRs take their defaults, then a clearing pass writes one store row
// per cycle over all VOXEL_COUNT rows, during which no beat is accepted.
module voxel_point_statistics_accumulator_core #(
   parameter int unsigned VOXEL_COUNT = vpsa_pkg::VOXEL_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [vpsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vpsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  vpsa_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output vpsa_pkg::rsp_type               rsp_data
);
   localparam int unsigned IDX_W = $clog2(VOXEL_COUNT);
   localparam int unsigned QW = 96 + IDX_W + 17;

   vpsa_pkg::cfg_type cfg_ff;
   logic fr_valid, fr_stall, fr_drop, fe_stall, fe_valid, busy;
   vpsa_pkg::req_type fr_point, q_point;
   logic [IDX_W-1:0] fr_index, q_index;
   logic [15:0] fr_index16, q_index16;
   logic q_valid, q_pop, q_drop;
   logic [QW-1:0] q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0; cfg_ff.origin_y <= '0; cfg_ff.origin_z <= '0;
         cfg_ff.inv_res <= 32'd65536; cfg_ff.grid_w <= 11'd64; cfg_ff.grid_h <= 11'd64;
      end else if (csr_we) begin
         case (csr_index)
            vpsa_pkg::CSR_ORIGIN_X: cfg_ff.origin_x <= csr_wdata;
            vpsa_pkg::CSR_ORIGIN_Y: cfg_ff.origin_y <= csr_wdata;
            vpsa_pkg::CSR_ORIGIN_Z: cfg_ff.origin_z <= csr_wdata;
            vpsa_pkg::CSR_INV_RES:  cfg_ff.inv_res  <= csr_wdata;
            vpsa_pkg::CSR_GRID_W:   cfg_ff.grid_w   <= csr_wdata[10:0];
            vpsa_pkg::CSR_GRID_H:   cfg_ff.grid_h   <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign fe_valid  = req_valid && !busy;
   assign req_stall = fe_stall || busy;

   vpsa_front #(.VOXEL_COUNT(VOXEL_COUNT), .IDX_W(IDX_W)) u_front (
      .clock, .reset, .cfg(cfg_ff), .req_valid(fe_valid), .req_stall(fe_stall),
      .req_data, .fr_valid, .fr_stall, .fr_point, .fr_index, .fr_index16, .fr_drop
   );

   vpsa_queue #(.W(QW)) u_queue (
      .clock, .reset, .in_valid(fr_valid), .in_stall(fr_stall),
      .in_data({fr_point, fr_index, fr_index16, fr_drop}),
      .out_valid(q_valid), .out_pop(q_pop), .out_data(q_out)
   );
   assign {q_point, q_index, q_index16, q_drop} = q_out;

   vpsa_back #(.VOXEL_COUNT(VOXEL_COUNT), .IDX_W(IDX_W)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_point, .q_index, .q_index16, .q_drop,
      .rsp_valid, .rsp_stall, .rsp_data, .busy_clear(busy)
   );

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall) else $error("beat accepted during clear");
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_grid |-> rsp_data.point_count == '0)
      else $error("dropped point carries data");
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_of_grid |-> rsp_data.point_count != '0)
      else $error("hit with zero count");
endmodule
